FILE: hw/rtl/rasm_pkg.sv
`default_nettype none

package rasm_pkg;

    localparam int WINDOW_DEPTH = 16;

    localparam int TEMP_W    = 12;
    localparam int CNT_OUT_W = 5;
    localparam int SLOT_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);
    // |sum| <= 2048 * depth, plus a sign bit
    localparam int SUM_W     = TEMP_W + 1 + $clog2(WINDOW_DEPTH);
    localparam int MAG_W     = SUM_W - 1;
    localparam int ITER_W    = $clog2(MAG_W + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARM_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_MAX  = 2'd2;

    localparam logic signed [TEMP_W-1:0] WARM_LIMIT_RESET = 12'sd80;
    localparam logic signed [TEMP_W-1:0] VALID_MIN_RESET  = -12'sd880;
    localparam logic signed [TEMP_W-1:0] VALID_MAX_RESET  = 12'sd2000;

    typedef enum logic [1:0] {
        STAT_NORMAL = 2'd0,
        STAT_WARM   = 2'd1,
        STAT_DOOR   = 2'd2,
        STAT_FAULT  = 2'd3
    } t_status;

    // one classified request between front and back
    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     door_is_open;
        logic                     sensor_error;
    } t_item;

    typedef struct packed {
        logic [FILL_W-1:0] filled;
        logic              pop;
    } t_back_mon;

endpackage

`default_nettype wire

FILE: hw/rtl/rasm_front.sv
`default_nettype none

module rasm_front (
    input  wire logic                                 i_in_valid,
    input  wire logic signed [rasm_pkg::TEMP_W-1:0]   i_temperature,
    input  wire logic                                 i_door_is_open,
    input  wire logic signed [rasm_pkg::TEMP_W-1:0]   i_valid_min,
    input  wire logic signed [rasm_pkg::TEMP_W-1:0]   i_valid_max,
    input  wire logic                                 i_q_full,
    output logic                                      o_in_stall,
    output logic                                      o_push,
    output rasm_pkg::t_item                           o_push_item
);

    logic out_of_range;

    // an inverted range flags every sample
    assign out_of_range = (i_temperature < i_valid_min) || (i_temperature > i_valid_max);

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_push_item.temperature  = i_temperature;
        o_push_item.door_is_open = i_door_is_open;
        o_push_item.sensor_error = out_of_range;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rasm_queue.sv
`default_nettype none

module rasm_queue (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire rasm_pkg::t_item                 i_push_item,
    input  wire logic                            i_pop,
    output rasm_pkg::t_item                      o_pop_item,
    output logic                                 o_full,
    output logic                                 o_nonempty,
    output logic [rasm_pkg::QLVL_W-1:0]          o_level
);

    rasm_pkg::t_item                 r_entry [rasm_pkg::QUEUE_DEPTH];
    logic [rasm_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [rasm_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [rasm_pkg::QLVL_W-1:0]     r_level;
    logic [rasm_pkg::QPTR_W-1:0]     n_wr_ptr;
    logic [rasm_pkg::QPTR_W-1:0]     n_rd_ptr;
    logic [rasm_pkg::QLVL_W-1:0]     n_level;

    localparam logic [rasm_pkg::QPTR_W-1:0] LAST_PTR = rasm_pkg::QPTR_W'(rasm_pkg::QUEUE_DEPTH - 1);

    assign o_full     = (r_level == rasm_pkg::QLVL_W'(rasm_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_level != '0);
    assign o_level    = r_level;
    assign o_pop_item = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_level  = r_level;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_level = r_level + 1'b1;
        end else if (i_pop && !i_push) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rasm_back.sv
`default_nettype none

module rasm_back (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_q_nonempty,
    input  wire rasm_pkg::t_item                      i_q_item,
    output logic                                      o_q_pop,
    input  wire logic signed [rasm_pkg::TEMP_W-1:0]   i_warm_limit,
    input  wire logic                                 i_out_stall,
    output logic                                      o_out_valid,
    output logic signed [rasm_pkg::TEMP_W-1:0]        o_average,
    output logic [1:0]                                o_status,
    output logic [rasm_pkg::CNT_OUT_W-1:0]            o_sample_count,
    output rasm_pkg::t_back_mon                       o_mon
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SUM  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    t_state                                   r_state, n_state;
    logic [rasm_pkg::SLOT_W-1:0]              r_slot, n_slot;
    logic [rasm_pkg::FILL_W-1:0]              r_filled, n_filled;
    logic signed [rasm_pkg::SUM_W-1:0]        r_sum, n_sum;
    logic                                     r_out_valid, n_out_valid;
    logic [rasm_pkg::ITER_W-1:0]              r_iter, n_iter;
    logic [rasm_pkg::MAG_W-1:0]               r_quo, n_quo;
    logic [rasm_pkg::FILL_W-1:0]              r_rem, n_rem;
    logic                                     r_neg, n_neg;
    rasm_pkg::t_item                          r_item;
    logic signed [rasm_pkg::TEMP_W-1:0]       r_old;
    logic signed [rasm_pkg::TEMP_W-1:0]       r_average;
    rasm_pkg::t_status                        r_status;
    logic [rasm_pkg::CNT_OUT_W-1:0]           r_count;

    logic signed [rasm_pkg::TEMP_W-1:0]       r_ring [rasm_pkg::WINDOW_DEPTH];

    logic                                     pop;
    logic                                     ring_write;
    logic                                     full;
    logic                                     load_out;
    logic signed [rasm_pkg::SUM_W-1:0]        sum_drop;
    logic signed [rasm_pkg::SUM_W-1:0]        sum_new;
    logic [rasm_pkg::FILL_W:0]                trial;
    logic                                     trial_ge;
    logic signed [rasm_pkg::TEMP_W-1:0]       avg;
    rasm_pkg::t_status                        status;

    localparam logic [rasm_pkg::SLOT_W-1:0] LAST_SLOT =
        rasm_pkg::SLOT_W'(rasm_pkg::WINDOW_DEPTH - 1);
    localparam logic [rasm_pkg::FILL_W-1:0] FULL_COUNT =
        rasm_pkg::FILL_W'(rasm_pkg::WINDOW_DEPTH);
    localparam logic [rasm_pkg::ITER_W-1:0] ITER_START =
        rasm_pkg::ITER_W'(rasm_pkg::MAG_W);

    assign full = (r_filled == FULL_COUNT);

    // once the window is full the overwritten sample leaves the sum
    assign sum_drop = full ? rasm_pkg::SUM_W'(r_old) : '0;
    assign sum_new  = r_sum - sum_drop + rasm_pkg::SUM_W'(r_item.temperature);

    // restoring divide, one quotient bit a cycle
    assign trial    = {r_rem, r_quo[rasm_pkg::MAG_W-1]};
    assign trial_ge = (trial >= {1'b0, r_filled});

    assign avg = r_neg ? -r_quo[rasm_pkg::TEMP_W-1:0] : r_quo[rasm_pkg::TEMP_W-1:0];

    always_comb begin
        if (r_item.sensor_error) begin
            status = rasm_pkg::STAT_FAULT;
        end else if (r_item.door_is_open) begin
            status = rasm_pkg::STAT_DOOR;
        end else if (avg > i_warm_limit) begin
            status = rasm_pkg::STAT_WARM;
        end else begin
            status = rasm_pkg::STAT_NORMAL;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_filled    = r_filled;
        n_sum       = r_sum;
        n_iter      = r_iter;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && i_out_stall;
        pop         = 1'b0;
        ring_write  = 1'b0;
        load_out    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_nonempty) begin
                    pop     = 1'b1;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                ring_write = 1'b1;
                n_sum      = sum_new;
                n_filled   = full ? r_filled : r_filled + 1'b1;
                n_slot     = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
                n_neg      = sum_new[rasm_pkg::SUM_W-1];
                n_quo      = sum_new[rasm_pkg::SUM_W-1] ?
                             rasm_pkg::MAG_W'(-sum_new) : rasm_pkg::MAG_W'(sum_new);
                n_rem      = '0;
                n_iter     = ITER_START;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                n_rem  = trial_ge ? rasm_pkg::FILL_W'(trial - {1'b0, r_filled})
                                  : rasm_pkg::FILL_W'(trial);
                n_quo  = {r_quo[rasm_pkg::MAG_W-2:0], trial_ge};
                n_iter = r_iter - 1'b1;
                if (r_iter == rasm_pkg::ITER_W'(1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_filled    <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_filled    <= n_filled;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iter <= n_iter;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_neg  <= n_neg;
        if (pop) begin
            r_item <= i_q_item;
        end
        if (load_out) begin
            r_average <= avg;
            r_status  <= status;
            r_count   <= rasm_pkg::CNT_OUT_W'(r_filled);
        end
    end

    // ring: registered read of the slot about to be overwritten
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_old <= r_ring[r_slot];
        end
        if (ring_write) begin
            r_ring[r_slot] <= r_item.temperature;
        end
    end

    assign o_q_pop        = pop;
    assign o_out_valid    = r_out_valid;
    assign o_average      = r_average;
    assign o_status       = r_status;
    assign o_sample_count = r_count;

    always_comb begin
        o_mon.filled = r_filled;
        o_mon.pop    = pop;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rolling_average_status_monitor_top.sv
`default_nettype none

// channel   valid        stall        payload
// -------   ----------   ----------   ---------------------------------------
// in        i_in_valid   o_in_stall   i_temperature, i_door_is_open
// out       o_out_valid  i_out_stall  o_average, o_status, o_sample_count
// cfg       i_cfg_we     -            i_cfg_index, i_cfg_data
//
// each request passes through the back end in order: a pop and ring read,
// a sum update, the serial divider (one step per quotient bit of the
// sum magnitude), a load of the output register. the next request is popped after that.
// synchronous active-low reset clears control, the fill count, the sum and the queue, and loads the config defaults.
// a two-entry queue lets the front take requests while the back divides;
// a stalled result holds the back end in its last step.

module rolling_average_status_monitor_top (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_in_valid,
    output logic                                           o_in_stall,
    input  wire logic signed [rasm_pkg::TEMP_W-1:0]        i_temperature,
    input  wire logic                                      i_door_is_open,
    output logic                                           o_out_valid,
    input  wire logic                                      i_out_stall,
    output logic signed [rasm_pkg::TEMP_W-1:0]             o_average,
    output logic [1:0]                                     o_status,
    output logic [rasm_pkg::CNT_OUT_W-1:0]                 o_sample_count,
    input  wire logic                                      i_cfg_we,
    input  wire logic [rasm_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  wire logic [rasm_pkg::TEMP_W-1:0]               i_cfg_data
);

    logic signed [rasm_pkg::TEMP_W-1:0] r_warm_limit;
    logic signed [rasm_pkg::TEMP_W-1:0] r_valid_min;
    logic signed [rasm_pkg::TEMP_W-1:0] r_valid_max;

    logic                               push;
    rasm_pkg::t_item                    push_item;
    rasm_pkg::t_item                    pop_item;
    logic                               q_full;
    logic                               q_nonempty;
    logic [rasm_pkg::QLVL_W-1:0]        q_level;
    logic                               q_pop;
    rasm_pkg::t_back_mon                back_mon;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm_limit <= rasm_pkg::WARM_LIMIT_RESET;
            r_valid_min  <= rasm_pkg::VALID_MIN_RESET;
            r_valid_max  <= rasm_pkg::VALID_MAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rasm_pkg::CFG_WARM_LIMIT: r_warm_limit <= i_cfg_data;
                rasm_pkg::CFG_VALID_MIN:  r_valid_min  <= i_cfg_data;
                rasm_pkg::CFG_VALID_MAX:  r_valid_max  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rasm_front u_front (
        .i_in_valid     (i_in_valid),
        .i_temperature  (i_temperature),
        .i_door_is_open (i_door_is_open),
        .i_valid_min    (r_valid_min),
        .i_valid_max    (r_valid_max),
        .i_q_full       (q_full),
        .o_in_stall     (o_in_stall),
        .o_push         (push),
        .o_push_item    (push_item)
    );

    rasm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (q_pop),
        .o_pop_item  (pop_item),
        .o_full      (q_full),
        .o_nonempty  (q_nonempty),
        .o_level     (q_level)
    );

    rasm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_nonempty   (q_nonempty),
        .i_q_item       (pop_item),
        .o_q_pop        (q_pop),
        .i_warm_limit   (r_warm_limit),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_average      (o_average),
        .o_status       (o_status),
        .o_sample_count (o_sample_count),
        .o_mon          (back_mon)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_mon.pop |-> (q_level != '0))
        else $error("back popped an empty queue");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_level <= rasm_pkg::QLVL_W'(rasm_pkg::QUEUE_DEPTH))
        else $error("queue level above depth");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_mon.filled <= rasm_pkg::FILL_W'(rasm_pkg::WINDOW_DEPTH))
        else $error("window fill count above depth");

    a_result_has_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (back_mon.filled != '0))
        else $error("result shown with an empty window");

endmodule

`default_nettype wire
